@@ sv/arp_pkg.sv @@
// ----------------------------------------------------------------------------
// arp_pkg: shared types and constants of the arpeggiator note sequencer
// Command codes, register indexes, list sizes and the control structs
// passed between the sequencer, the held-note list and the config block.
// ----------------------------------------------------------------------------
`default_nettype none

package arp_pkg;

	localparam int MAX_HELD  = 12;
	localparam int PAD_COUNT = 12;

	localparam int PAD_W   = 4;
	localparam int COUNT_W = 4;
	localparam int STEP_W  = 32;
	localparam int IVAL_W  = 32;
	localparam int CD_W    = 34;

	localparam logic [1:0] CMD_TICK   = 2'd0;
	localparam logic [1:0] CMD_UPDATE = 2'd1;
	localparam logic [1:0] CMD_CLEAR  = 2'd2;

	localparam logic [1:0] ORDER_RANDOM = 2'd2;

	localparam logic REG_ORDER_MODE = 1'b0;
	localparam logic REG_INTERVAL   = 1'b1;

	localparam logic [1:0]  ORDER_MODE_RST = 2'd0;
	localparam logic [31:0] INTERVAL_RST   = 32'd12288000;
	localparam logic [31:0] RANDOM_SEED    = 32'h1234_5678;
	localparam logic [CD_W-1:0] ONE_SAMPLE = CD_W'(256);

	typedef struct packed {
		logic [1:0]        order_mode;
		logic [IVAL_W-1:0] interval;
		logic              mode_wr;
	} cfg_t;

	typedef struct packed {
		logic             press;
		logic             release_pad;
		logic             clear;
		logic [PAD_W-1:0] pad;
	} list_op_t;

endpackage

`default_nettype wire

@@ sv/arp_cfg.sv @@
// ----------------------------------------------------------------------------
// arp_cfg: configuration registers
// APB-style register port holding the order mode and the note interval.
// Flags a write of the order mode so the step counter can be cleared.
// ----------------------------------------------------------------------------
`default_nettype none

module arp_cfg
	import arp_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        psel,
	input  wire logic        penable,
	input  wire logic        pwrite,
	input  wire logic [2:0]  paddr,
	input  wire logic [31:0] pwdata,
	output logic      [31:0] prdata,
	output logic             pready,
	output cfg_t             cfg
);

	logic [1:0]        order_mode_q;
	logic [IVAL_W-1:0] interval_q;
	logic              wr_en;

	assign wr_en  = psel & penable & pwrite;
	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			order_mode_q <= ORDER_MODE_RST;
			interval_q   <= INTERVAL_RST;
		end else if (wr_en) begin
			if (paddr[2] == REG_ORDER_MODE) begin
				order_mode_q <= pwdata[1:0];
			end else begin
				interval_q <= pwdata;
			end
		end
	end

	always_comb begin
		if (paddr[2] == REG_INTERVAL) begin
			prdata = interval_q;
		end else begin
			prdata = {30'd0, order_mode_q};
		end
	end

	assign cfg.order_mode = order_mode_q;
	assign cfg.interval   = interval_q;
	assign cfg.mode_wr    = wr_en & (paddr[2] == REG_ORDER_MODE);

endmodule

`default_nettype wire

@@ sv/arp_list.sv @@
// ----------------------------------------------------------------------------
// arp_list: held-note list
// Insertion-ordered list of held pads with a membership mask. Takes one
// press, release or clear per cycle; release closes the gap in one step.
// ----------------------------------------------------------------------------
`default_nettype none

module arp_list
	import arp_pkg::*;
(
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire list_op_t           op,
	input  wire logic [PAD_W-1:0]   rd_idx,
	output logic      [PAD_W-1:0]   rd_pad,
	output logic      [COUNT_W-1:0] total
);

	logic [PAD_W-1:0]     entries_q [MAX_HELD];
	logic [COUNT_W-1:0]   total_q;
	logic [PAD_COUNT-1:0] mask_q;
	logic [MAX_HELD-1:0]  hit;
	logic [MAX_HELD-1:0]  from_hit;
	logic                 is_held;
	logic                 has_room;

	assign is_held  = mask_q[op.pad];
	assign has_room = total_q < COUNT_W'(MAX_HELD);

	// locate the released pad and mark it and every entry after it
	always_comb begin
		for (int k = 0; k < MAX_HELD; k++) begin
			hit[k] = (entries_q[k] == op.pad) && (COUNT_W'(k) < total_q);
		end
		from_hit[0] = hit[0];
		for (int k = 1; k < MAX_HELD; k++) begin
			from_hit[k] = from_hit[k-1] | hit[k];
		end
	end

	always_ff @(posedge clk) begin
		if (op.press && !is_held && has_room) begin
			entries_q[total_q] <= op.pad;
		end else if (op.release_pad && is_held) begin
			for (int k = 0; k < MAX_HELD - 1; k++) begin
				if (from_hit[k]) begin
					entries_q[k] <= entries_q[k+1];
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			total_q <= '0;
			mask_q  <= '0;
		end else if (op.clear) begin
			total_q <= '0;
			mask_q  <= '0;
		end else if (op.press && !is_held && has_room) begin
			total_q         <= total_q + COUNT_W'(1);
			mask_q[op.pad]  <= 1'b1;
		end else if (op.release_pad && is_held) begin
			total_q         <= total_q - COUNT_W'(1);
			mask_q[op.pad]  <= 1'b0;
		end
	end

	assign rd_pad = entries_q[rd_idx];
	assign total  = total_q;

endmodule

`default_nettype wire

@@ sv/arp_mod.sv @@
// ----------------------------------------------------------------------------
// arp_mod: iterative modulo unit
// Restoring division of a 32-bit value by the held count, one quotient
// bit per cycle; only the remainder is kept. Done pulses after 32 steps.
// ----------------------------------------------------------------------------
`default_nettype none

module arp_mod
	import arp_pkg::*;
(
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               start,
	input  wire logic [STEP_W-1:0]  dividend,
	input  wire logic [COUNT_W-1:0] divisor,
	output logic                    done,
	output logic      [PAD_W-1:0]   rem
);

	typedef logic [$clog2(STEP_W)-1:0] step_cnt_t;

	logic [STEP_W-1:0]  divd_q;
	logic [COUNT_W-1:0] div_q;
	logic [COUNT_W:0]   rem_q;
	step_cnt_t          cnt_q;
	logic               busy_q;
	logic               done_q;
	logic [COUNT_W:0]   trial;
	logic               fits;

	assign trial = {rem_q[COUNT_W-1:0], divd_q[STEP_W-1]};
	assign fits  = trial >= {1'b0, div_q};

	always_ff @(posedge clk) begin
		if (start) begin
			divd_q <= dividend;
			div_q  <= divisor;
			rem_q  <= '0;
		end else if (busy_q) begin
			divd_q <= {divd_q[STEP_W-2:0], 1'b0};
			rem_q  <= fits ? trial - {1'b0, div_q} : trial;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + step_cnt_t'(1);
				if (cnt_q == step_cnt_t'(STEP_W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	assign done = done_q;
	assign rem  = rem_q[PAD_W-1:0];

endmodule

`default_nettype wire

@@ sv/arpeggiator_note_sequencer_top.sv @@
// ----------------------------------------------------------------------------
// arpeggiator_note_sequencer_top: arpeggiator over 12 pads
// Keeps the held-pad list, counts down the note interval and picks the
// next note in forward or random order.
// ----------------------------------------------------------------------------
// Input channel (in_valid/in_stall) carries one command per transfer: a
// sample tick, a pad-mask update or a clear. Every input transfer yields
// exactly one result transfer on the output channel (out_valid/out_stall)
// with fired, note and the held count after the item.
// A pad update walks the pads one per cycle, a tick that fires waits for
// the 32-step modulo unit, and other items go straight to the result.
// The block takes one item at a time; in_stall is high while an item is
// at work and drops as the result is loaded into the output register.
// A new item is taken while the previous result waits; if the receiver
// still stalls when the next result is ready, the sequencer holds it and
// keeps in_stall high.
// Reset empties the list, zeroes the step counter and countdown, seeds the
// random generator and loads the register defaults. Configure only while
// idle; a write to the order mode also zeroes the step counter.
// ----------------------------------------------------------------------------
`default_nettype none

module arpeggiator_note_sequencer_top
	import arp_pkg::*;
(
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         psel,
	input  wire logic         penable,
	input  wire logic         pwrite,
	input  wire logic [2:0]   paddr,
	input  wire logic [31:0]  pwdata,
	output logic      [31:0]  prdata,
	output logic              pready,
	input  wire logic         in_valid,
	output logic              in_stall,
	input  wire logic [1:0]   command,
	input  wire logic [11:0]  pads_now,
	input  wire logic [11:0]  pads_before,
	output logic              out_valid,
	input  wire logic         out_stall,
	output logic              fired,
	output logic      [3:0]   note,
	output logic      [3:0]   held_count
);

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_UPD  = 2'd1;
	localparam logic [1:0] ST_DIV  = 2'd2;
	localparam logic [1:0] ST_DONE = 2'd3;

	cfg_t                 cfg;
	list_op_t             op;
	logic [1:0]           state_q;
	logic [PAD_W-1:0]     pad_idx_q;
	logic [PAD_COUNT-1:0] now_q;
	logic [PAD_COUNT-1:0] changed_q;
	logic                 fired_q;
	logic [PAD_W-1:0]     note_q;
	logic [STEP_W-1:0]    step_q;
	logic [31:0]          rand_q;
	logic [CD_W-1:0]      countdown_q;
	logic                 out_valid_q;
	logic                 out_fired_q;
	logic [PAD_W-1:0]     out_note_q;
	logic [COUNT_W-1:0]   out_count_q;

	logic                 accept;
	logic                 is_tick;
	logic                 random_mode;
	logic [31:0]          rand_next;
	logic [CD_W:0]        cd_ext;
	logic [CD_W-1:0]      cd_sub;
	logic                 cd_fire;
	logic                 mod_start;
	logic [STEP_W-1:0]    mod_dividend;
	logic                 mod_done;
	logic [PAD_W-1:0]     mod_rem;
	logic [PAD_W-1:0]     list_pad;
	logic [COUNT_W-1:0]   list_total;
	logic                 out_free;
	logic                 out_load;

	function automatic logic [31:0] xorshift(input logic [31:0] s);
		logic [31:0] x;
		x = s;
		x = x ^ (x << 13);
		x = x ^ (x >> 17);
		x = x ^ (x << 5);
		return x;
	endfunction

	arp_cfg u_cfg (
		.clk    (clk),
		.arst_n (arst_n),
		.psel   (psel),
		.penable(penable),
		.pwrite (pwrite),
		.paddr  (paddr),
		.pwdata (pwdata),
		.prdata (prdata),
		.pready (pready),
		.cfg    (cfg)
	);

	arp_list u_list (
		.clk    (clk),
		.arst_n (arst_n),
		.op     (op),
		.rd_idx (mod_rem),
		.rd_pad (list_pad),
		.total  (list_total)
	);

	arp_mod u_mod (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (mod_start),
		.dividend (mod_dividend),
		.divisor  (list_total),
		.done     (mod_done),
		.rem      (mod_rem)
	);

	assign in_stall    = (state_q != ST_IDLE);
	assign accept      = in_valid & ~in_stall;
	assign is_tick     = (command == CMD_TICK) && (list_total != '0);
	assign random_mode = (cfg.order_mode == ORDER_RANDOM);
	assign rand_next   = xorshift(rand_q);
	assign out_free    = ~out_valid_q | ~out_stall;
	assign out_load    = (state_q == ST_DONE) & out_free;

	// one-sample decrement, saturating at the most negative countdown
	assign cd_ext  = {countdown_q[CD_W-1], countdown_q} - {1'b0, ONE_SAMPLE};
	assign cd_sub  = (cd_ext[CD_W] != cd_ext[CD_W-1]) ? {1'b1, {(CD_W-1){1'b0}}}
	                                                  : cd_ext[CD_W-1:0];
	assign cd_fire = cd_sub[CD_W-1] | (cd_sub == '0);

	assign mod_start    = accept & is_tick & cd_fire;
	assign mod_dividend = random_mode ? rand_next : step_q;

	always_comb begin
		op.press       = 1'b0;
		op.release_pad = 1'b0;
		op.clear       = accept && (command == CMD_CLEAR);
		op.pad         = pad_idx_q;
		if (state_q == ST_UPD && changed_q[pad_idx_q]) begin
			op.press       = now_q[pad_idx_q];
			op.release_pad = ~now_q[pad_idx_q];
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			now_q     <= pads_now;
			changed_q <= pads_now ^ pads_before;
			fired_q   <= 1'b0;
			note_q    <= '0;
		end else if (state_q == ST_DIV && mod_done) begin
			fired_q <= 1'b1;
			note_q  <= list_pad;
		end
		if (out_load) begin
			out_fired_q <= fired_q;
			out_note_q  <= note_q;
			out_count_q <= list_total;
		end
	end

	// step counter: zero on a mode write or a clear, advance on a forward note
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q <= '0;
		end else if (cfg.mode_wr || op.clear) begin
			step_q <= '0;
		end else if (mod_start && !random_mode) begin
			step_q <= step_q + STEP_W'(1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			pad_idx_q   <= '0;
			rand_q      <= RANDOM_SEED;
			countdown_q <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						pad_idx_q <= '0;
						if (command == CMD_UPDATE) begin
							state_q <= ST_UPD;
						end else if (command == CMD_CLEAR) begin
							state_q <= ST_DONE;
						end else if (is_tick) begin
							countdown_q <= cd_sub;
							if (cd_fire) begin
								if (random_mode) begin
									rand_q <= rand_next;
								end
								state_q <= ST_DIV;
							end else begin
								state_q <= ST_DONE;
							end
						end else begin
							state_q <= ST_DONE;
						end
					end
				end
				ST_UPD: begin
					pad_idx_q <= pad_idx_q + PAD_W'(1);
					if (pad_idx_q == PAD_W'(PAD_COUNT - 1)) begin
						state_q <= ST_DONE;
					end
				end
				ST_DIV: begin
					if (mod_done) begin
						countdown_q <= countdown_q + {{(CD_W-IVAL_W){1'b0}}, cfg.interval};
						state_q     <= ST_DONE;
					end
				end
				ST_DONE: begin
					// hold the result until the output register is free
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign out_valid  = out_valid_q;
	assign fired      = out_fired_q;
	assign note       = out_note_q;
	assign held_count = out_count_q;

endmodule

`default_nettype wire
